// ===== hw/rtl/wsr_pkg.sv =====
// Shared types and constants for the wildcard star pattern matcher.
`timescale 1ns / 1ps

package wsr_pkg;

  localparam int LEN_W  = 6;
  localparam int POS_W  = 5;
  localparam int CHAR_W = 8;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ANY  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

  typedef struct packed {
    logic wr_char;
    logic start;
    logic step;
    logic prop;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/wsr_cell.sv =====
// One pattern position: its stored character and its bit of the match row.
`timescale 1ns / 1ps

module wsr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  wsr_pkg::cell_ctl_t        ctl,
  input  logic [wsr_pkg::CHAR_W-1:0] character,
  input  logic                      sel,
  input  logic                      active,
  input  logic                      has_prev,
  input  logic [wsr_pkg::CHAR_W-1:0] prev_ch,
  input  logic                      prev_bit,
  input  logic                      low_bit,
  output logic [wsr_pkg::CHAR_W-1:0] ch,
  output logic                      row_bit,
  output logic                      grow
);
  import wsr_pkg::*;

  logic [CHAR_W-1:0] ch_q;
  logic              row_q;
  logic              is_star;
  logic              fits;
  logic              prev_fits;
  logic              local_val;
  logic              link;

  assign is_star   = (ch_q == CH_STAR);
  assign fits      = (ch_q == CH_ANY) || (ch_q == character);
  assign prev_fits = (prev_ch == CH_ANY) || (prev_ch == character);

  // A star keeps its own bit when the repeated element takes the character;
  // any other element moves the bit up from its lower neighbour.
  assign local_val = active & (is_star ? (has_prev & row_q & prev_fits) : (fits & prev_bit));

  // A star may also skip its element: it takes the bit two positions down.
  assign link = active & has_prev & is_star & low_bit;
  assign grow = link & ~row_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_char && sel) begin
      ch_q <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= 1'b0;
    end else if (ctl.start) begin
      row_q <= 1'b0;
    end else if (ctl.step) begin
      row_q <= local_val;
    end else if (ctl.prop) begin
      row_q <= row_q | link;
    end
  end

  assign ch      = ch_q;
  assign row_bit = row_q;

endmodule

// ===== hw/rtl/wildcard_star_regex_matcher.sv =====
// Top level of the wildcard star pattern matcher: control, cell row and output register.
`timescale 1ns / 1ps

// Pattern characters are written into a row of cells, one cell for each pattern position,
// and each cell holds its bit of the match row. In the cycle a request is accepted, a
// begin request clears the row and sets its empty-prefix bit, and a text request forms
// every cell's local term; the bits that a star gains by skipping its element then travel
// up the row two cells a cycle until the row has settled, and the result is taken from it.
// A finished row is held until the output register is free, so a result that has not been
// taken delays the one after it. The next request is taken in the cycle after the result
// is registered, and a result may wait in the output register while the next request is
// worked on.
module wildcard_star_regex_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wsr_pkg::LEN_W-1:0]  cfg_data,      // pattern_length
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // position[4:0], character[12:5]
  input  logic [wsr_pkg::FUNC_W-1:0] s_axis_tuser,  // func[1:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata   // matched[0]
);
  import wsr_pkg::*;

  localparam int N_W = $clog2(MAX_PATTERN + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROP = 1'b1;

  logic              state;
  logic [LEN_W-1:0]  pattern_length;
  logic [N_W-1:0]    used_len;
  logic              acc;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [CHAR_W-1:0] character;
  cell_ctl_t         ctl;
  logic              row0;
  logic [MAX_PATTERN:0]  row;
  logic [MAX_PATTERN:1]  grow;
  logic [MAX_PATTERN:1]  sel;
  logic [MAX_PATTERN:1]  active;
  logic [CHAR_W-1:0]     pch [0:MAX_PATTERN];
  logic              settled;
  logic              out_free;
  logic              matched;

  assign func      = s_axis_tuser;
  assign position  = s_axis_tdata[4:0];
  assign character = s_axis_tdata[12:5];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;

  assign used_len = (pattern_length > LEN_W'(MAX_PATTERN)) ? N_W'(MAX_PATTERN)
                                                           : N_W'(pattern_length);

  always_comb begin
    ctl = '0;
    if (acc) begin
      case (func)
        FUNC_LOAD:  ctl.wr_char = 1'b1;
        FUNC_BEGIN: ctl.start   = 1'b1;
        FUNC_TEXT:  ctl.step    = 1'b1;
        default:    ctl         = '0;
      endcase
    end
    ctl.prop = (state == ST_PROP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pattern_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row0 <= 1'b1;
    end else if (ctl.start) begin
      row0 <= 1'b1;
    end else if (ctl.step) begin
      row0 <= 1'b0;
    end
  end

  assign row[0] = row0;
  assign pch[0] = '0;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic low_bit;

    assign sel[j]    = (32'(position) == 32'(j - 1));
    assign active[j] = (32'(used_len) >= 32'(j));

    if (j >= 2) begin : g_low
      assign low_bit = row[j-2];
    end else begin : g_first
      assign low_bit = 1'b0;
    end

    wsr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .character (character),
      .sel       (sel[j]),
      .active    (active[j]),
      .has_prev  ((j >= 2) ? 1'b1 : 1'b0),
      .prev_ch   (pch[j-1]),
      .prev_bit  (row[j-1]),
      .low_bit   (low_bit),
      .ch        (pch[j]),
      .row_bit   (row[j]),
      .grow      (grow[j])
    );
  end

  assign settled  = ~|grow;
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
          if (ctl.start || ctl.step) begin
            state <= ST_PROP;
          end
        end
        ST_PROP: begin
          if (settled && out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PROP && settled && out_free) begin
      matched <= row[used_len];
    end
  end

  assign m_axis_tdata = {7'd0, matched};

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == FUNC_BEGIN || func == FUNC_TEXT)) |=> !s_axis_tready)
    else $error("matcher took a new request while a row was being built");

  a_begin_sets_empty: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FUNC_BEGIN) |=> row[0])
    else $error("begin request did not set the empty-prefix bit");

  a_result_from_prop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_PROP && settled))
    else $error("result presented before the row had settled");

  a_settled_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FUNC_LOAD && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("load request produced a result");

endmodule

// ===== test/tb_wildcard_star_regex_matcher.sv =====
// Self-checking testbench for the wildcard star pattern matcher, with its own match-row predictor.
`timescale 1ns / 1ps

module tb_wildcard_star_regex_matcher;
  import wsr_pkg::*;

  localparam int MAX_PATTERN = 32;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_B = 8'h62;
  localparam logic [CHAR_W-1:0] CH_C = 8'h63;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;  // position[4:0], character[12:5]
  logic [FUNC_W-1:0] s_axis_tuser = '0;  // func[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;      // matched[0]

  // Predictor state: pattern store, match row and the length register.
  logic [CHAR_W-1:0] pattern_chars [MAX_PATTERN];
  bit                pattern_written [MAX_PATTERN];
  logic [MAX_PATTERN:0] match_row = 1;
  logic [LEN_W-1:0]  length_reg = '0;

  bit                pending_matches [$];
  bit                expected_bit;
  bit                no_idle = 1'b0;
  int                sink_wait = 0;
  int                mismatches = 0;

  wildcard_star_regex_matcher #(.MAX_PATTERN(MAX_PATTERN)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_length();
    return (length_reg > MAX_PATTERN) ? MAX_PATTERN : int'(length_reg);
  endfunction

  function automatic bit element_fits(logic [CHAR_W-1:0] pc, logic [CHAR_W-1:0] c);
    return (pc == CH_ANY) || (pc == c);
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_PATTERN && pattern_written[n]) n++;
    return n;
  endfunction

  function automatic void predict_match(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                        logic [CHAR_W-1:0] ch);
    logic [MAX_PATTERN:0] next_row;
    int n;
    n = active_length();
    case (func)
      FUNC_LOAD: begin
        pattern_chars[pos] = ch;
        pattern_written[pos] = 1'b1;
      end
      FUNC_BEGIN: begin
        next_row = 1;
        for (int j = 1; j <= n; j++) begin
          if (j >= 2 && pattern_chars[j-1] == CH_STAR && next_row[j-2]) next_row[j] = 1'b1;
        end
        match_row = next_row;
        pending_matches.push_back(match_row[n]);
      end
      FUNC_TEXT: begin
        next_row = '0;
        for (int j = 1; j <= n; j++) begin
          if (pattern_chars[j-1] == CH_STAR) begin
            // A star at the very start has nothing to repeat and so never matches.
            if (j >= 2) begin
              next_row[j] = next_row[j-2] ||
                            (match_row[j] && element_fits(pattern_chars[j-2], ch));
            end
          end else begin
            next_row[j] = match_row[j-1] && element_fits(pattern_chars[j-1], ch);
          end
        end
        match_row = next_row;
        pending_matches.push_back(match_row[n]);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s, expected %b, got %b", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_matches.size() == 0) begin
          note_mismatch("result with no request outstanding", 1'bx, m_axis_tdata[0]);
        end else begin
          expected_bit = pending_matches.pop_front();
          if (m_axis_tdata[0] !== expected_bit) begin
            note_mismatch("matched", expected_bit, m_axis_tdata[0]);
          end
        end
        sink_wait = no_idle ? 0 : $urandom_range(0, 17);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
    end
    m_axis_tready <= (sink_wait == 0);
  end

  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {3'b000, ch, pos};
    do @(posedge clk); while (!s_axis_tready);
    predict_match(func, pos, ch);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_reg = len;
  endtask

  function automatic logic [CHAR_W-1:0] pattern_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_A;
      3:       return CH_B;
      4, 5:    return CH_ANY;
      6, 7, 8: return CH_STAR;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CH_A;
      5, 6:          return CH_B;
      7:             return CH_STAR;
      8:             return CH_ANY;
      default:       return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Text before any begin runs from the reset row; an unused function code is ignored.
  task automatic test_reset_row();
    send_request(FUNC_TEXT, 5'd0, CH_STAR);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    send_request(FUNC_UNUSED, 5'd31, 8'hFF);
    send_request(FUNC_TEXT, 5'd31, 8'hFF);
  endtask

  task automatic test_leading_star();
    write_length(6'd2);
    send_request(FUNC_LOAD, 5'd0, CH_STAR);
    send_request(FUNC_LOAD, 5'd1, CH_A);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    send_request(FUNC_TEXT, 5'd0, CH_A);
    send_request(FUNC_TEXT, 5'd0, CH_STAR);
  endtask

  // A star in the text is an ordinary character, while in the pattern it repeats the element before it.
  task automatic test_star_text();
    send_request(FUNC_LOAD, 5'd0, CH_ANY);
    send_request(FUNC_LOAD, 5'd1, CH_STAR);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    send_request(FUNC_TEXT, 5'd0, CH_STAR);
    send_request(FUNC_TEXT, 5'd0, 8'h00);
  endtask

  task automatic test_length_change();
    send_request(FUNC_LOAD, 5'd0, CH_A);
    send_request(FUNC_LOAD, 5'd1, CH_B);
    send_request(FUNC_LOAD, 5'd2, CH_ANY);
    send_request(FUNC_LOAD, 5'd3, CH_C);
    write_length(6'd4);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    send_request(FUNC_TEXT, 5'd0, CH_A);
    send_request(FUNC_TEXT, 5'd0, CH_B);
    write_length(6'd2);
    send_request(FUNC_TEXT, 5'd0, CH_B);
    write_length(6'd4);
    send_request(FUNC_TEXT, 5'd0, CH_C);
  endtask

  task automatic test_full_pattern();
    for (int p = 0; p < MAX_PATTERN; p++) send_request(FUNC_LOAD, POS_W'(p), pattern_char());
    write_length(6'd32);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    repeat (20) send_request(FUNC_TEXT, 5'd0, text_char());
    write_length(6'd63);
    repeat (10) send_request(FUNC_TEXT, 5'd0, text_char());
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    write_length(6'd0);
    send_request(FUNC_TEXT, 5'd0, text_char());
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    write_length(6'd33);
    send_request(FUNC_BEGIN, 5'd0, 8'h00);
    repeat (10) send_request(FUNC_TEXT, 5'd0, text_char());
  endtask

  task automatic test_random_texts();
    int sent;
    int plen;
    int len;
    int texts;
    int chars;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      no_idle = ($urandom_range(0, 3) == 0);
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_PATTERN) : $urandom_range(1, 6);
      for (int p = 0; p < plen; p++) begin
        send_request(FUNC_LOAD, POS_W'(p), pattern_char());
        sent++;
      end
      len = plen;
      if (plen == MAX_PATTERN && $urandom_range(0, 1) == 1) len = $urandom_range(33, 63);
      write_length(LEN_W'(len));
      texts = $urandom_range(1, 3);
      repeat (texts) begin
        send_request(FUNC_BEGIN, POS_W'($urandom_range(0, 31)), CHAR_W'($urandom_range(0, 255)));
        sent++;
        chars = $urandom_range(0, 10);
        repeat (chars) begin
          case ($urandom_range(0, 19))
            0: send_request(FUNC_UNUSED, POS_W'($urandom_range(0, 31)),
                            CHAR_W'($urandom_range(0, 255)));
            1: begin
              send_request(FUNC_LOAD, POS_W'($urandom_range(0, 31)), pattern_char());
              sent++;
            end
            2: begin
              // Hold off until every result is back, sometimes changing the length mid-text.
              drain_results();
              if ($urandom_range(0, 1) == 1) write_length(LEN_W'($urandom_range(0, written_prefix())));
            end
            default: begin
              send_request(FUNC_TEXT, POS_W'($urandom_range(0, 31)), text_char());
              sent++;
            end
          endcase
        end
      end
    end
  endtask

  initial begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      pattern_chars[p] = '0;
      pattern_written[p] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_row();
    test_leading_star();
    test_star_text();
    test_length_change();
    test_full_pattern();
    test_random_texts();
    drain_results();
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
